@@ hw/rtl/cptq_pkg.sv @@
// shared types, codes and field widths of the cancellable priority task queue
package cptq_pkg;

   // field widths of one beat
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int HANDLE_W   = 16;
   localparam int PRIO_W     = 4;
   localparam int TIME_W     = 48;
   localparam int KEY_W      = 32;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 32;

   // command codes on the request side
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DRAIN  = 3'd4;

   // status codes on the response side
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TASK     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

   // capacity register reset value
   localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

   // one queue slot as held in the entry memory
   typedef struct packed {
      logic                cancelled;
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
      logic [TIME_W-1:0]   ctime;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

   // compare unit result
   typedef struct packed {
      logic precedes;  // stored entry stays ahead of the new item
      logic key_hit;   // stored key equals the item key
   } cmp_type;

endpackage

@@ hw/rtl/cptq_cmp.sv @@
// shared compare unit: ordering and key match of one stored entry against the current item
module cptq_cmp (
   input  cptq_pkg::entry_type              entry,
   input  logic [cptq_pkg::PRIO_W-1:0]      item_prio,
   input  logic [cptq_pkg::TIME_W-1:0]      item_time,
   input  logic [cptq_pkg::KEY_W-1:0]       item_key,
   output cptq_pkg::cmp_type                result
);

   logic prio_lt;
   logic prio_eq;
   logic time_le;

   // priority first, then creation time, ties stay in arrival order
   assign prio_lt = entry.prio < item_prio;
   assign prio_eq = entry.prio == item_prio;
   assign time_le = entry.ctime <= item_time;

   assign result.precedes = prio_lt | (prio_eq & time_le);
   assign result.key_hit  = entry.key == item_key;

endmodule

@@ hw/rtl/cptq_store.sv @@
// entry memory: one write port, one read port with registered read data
module cptq_store #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  cptq_pkg::entry_type         wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output cptq_pkg::entry_type         rd_data
);

   cptq_pkg::entry_type mem [DEPTH];
   cptq_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cancellable_priority_task_queue_unit.sv @@
// top level: sequencer, queue state and response register of the task queue
//
//  channel  | direction | tdata                                  | tuser   | tlast
//  ---------+-----------+----------------------------------------+---------+------
//  req_     | in        | handle, priority, created time, key    | command | -
//  rsp_     | out       | handle, cancel count, occupancy, stop  | status  | last
//  csr_     | in        | capacity limit (write only)            | -       | -
//
// Sorted circular memory, one read and one write a cycle. Push moves entries up from the tail
// until the new one fits; pop removes entries from the front up to the first live one; cancel
// reads every occupied slot; drain reads until the last live entry; stop and rejected items
// go straight to the response.
// Reset clears control state only; no clearing pass. A stalled response holds
// the sequencer only where a further beat must be produced.
module cancellable_priority_task_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request beat
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] task_handle, [19:16] task_priority, [67:20] created_time,
   // [99:68] source_key, [103:100] zero
   input  logic [cptq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [2:0] command
   input  logic [cptq_pkg::CMD_W-1:0]          req_tuser,
   // response beat
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] out_handle, [20:16] cancel_count, [25:21] occupancy,
   // [26] is_stopped, [31:27] zero
   output logic [cptq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [cptq_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                rsp_tlast,
   // capacity register
   input  logic                                csr_wr_en,
   input  logic [cptq_pkg::COUNT_W-1:0]        csr_wr_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH_RD,
      S_PUSH_CMP,
      S_POP_RD,
      S_POP_CHK,
      S_CAN_RD,
      S_CAN_CHK,
      S_DRN_RD,
      S_DRN_CHK,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // queue state
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic             stop_ff, stop_in;
   logic [cptq_pkg::COUNT_W-1:0] cap_ff, cap_in;

   // sequencer counters
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // current item
   logic [cptq_pkg::HANDLE_W-1:0] itm_handle_ff, itm_handle_in;
   logic [cptq_pkg::PRIO_W-1:0]   itm_prio_ff, itm_prio_in;
   logic [cptq_pkg::TIME_W-1:0]   itm_time_ff, itm_time_in;
   logic [cptq_pkg::KEY_W-1:0]    itm_key_ff, itm_key_in;

   // pending result of a single-beat command
   logic [cptq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [cptq_pkg::HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [cptq_pkg::COUNT_W-1:0]  res_count_ff, res_count_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cptq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [cptq_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [cptq_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [cptq_pkg::COUNT_W-1:0]  rsp_occ_ff, rsp_occ_in;
   logic                          rsp_stop_ff, rsp_stop_in;
   logic                          rsp_last_ff, rsp_last_in;

   // memory and compare unit hookup
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   cptq_pkg::entry_type  mem_wr_data;
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   cptq_pkg::entry_type  mem_rd_data;
   cptq_pkg::entry_type  new_entry;
   cptq_pkg::cmp_type    cmp;

   logic [CNT_W-1:0] rd_pos;
   logic [SUM_W-1:0] rd_sum;
   logic [SUM_W-1:0] rd_phys;
   logic [SUM_W-1:0] wr_sum;
   logic [SUM_W-1:0] wr_phys;
   logic [IDX_W-1:0] head_next;
   logic [31:0]      fill_w32;
   logic [31:0]      count_w32;
   logic [31:0]      cap_w32;
   logic             full;
   logic             rsp_free;
   logic             req_beat;

   // request field unpacking
   assign itm_handle_in = (req_beat) ? req_tdata[15:0]  : itm_handle_ff;
   assign itm_prio_in   = (req_beat) ? req_tdata[19:16] : itm_prio_ff;
   assign itm_time_in   = (req_beat) ? req_tdata[67:20] : itm_time_ff;
   assign itm_key_in    = (req_beat) ? req_tdata[99:68] : itm_key_ff;

   assign req_tready = state_ff == S_IDLE;
   assign req_beat   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // logical queue position to memory address, wrapping at the depth
   assign rd_pos  = (state_ff == S_PUSH_RD) ? pos_ff - CNT_W'(1) : pos_ff;
   assign rd_sum  = SUM_W'(head_ff) + SUM_W'(rd_pos);
   assign rd_phys = (rd_sum >= SUM_W'(DEPTH)) ? rd_sum - SUM_W'(DEPTH) : rd_sum;
   assign wr_sum  = SUM_W'(head_ff) + SUM_W'(pos_ff);
   assign wr_phys = (wr_sum >= SUM_W'(DEPTH)) ? wr_sum - SUM_W'(DEPTH) : wr_sum;
   assign mem_rd_addr = rd_phys[IDX_W-1:0];
   assign mem_wr_addr = wr_phys[IDX_W-1:0];
   assign head_next   = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);

   // capacity above the depth acts as the depth
   assign fill_w32  = 32'(fill_ff);
   assign count_w32 = 32'(count_ff);
   assign cap_w32   = (32'(cap_ff) < 32'(DEPTH)) ? 32'(cap_ff) : 32'(DEPTH);
   assign full      = fill_w32 >= cap_w32;

   assign new_entry.cancelled = 1'b0;
   assign new_entry.handle    = itm_handle_ff;
   assign new_entry.key       = itm_key_ff;
   assign new_entry.ctime     = itm_time_ff;
   assign new_entry.prio      = itm_prio_ff;

   cptq_cmp u_cmp (
      .entry     (mem_rd_data),
      .item_prio (itm_prio_ff),
      .item_time (itm_time_ff),
      .item_key  (itm_key_ff),
      .result    (cmp)
   );

   cptq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      live_in       = live_ff;
      stop_in       = stop_ff;
      cap_in        = (csr_wr_en) ? csr_wr_data : cap_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_stop_in   = rsp_stop_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_data   = new_entry;
      mem_rd_en     = 1'b0;

      case (state_ff)
         // take one item and dispatch on its command
         S_IDLE: begin
            if (req_beat) begin
               res_handle_in = '0;
               res_count_in  = '0;
               pos_in        = '0;
               count_in      = '0;
               state_in      = S_EMIT;
               case (req_tuser)
                  cptq_pkg::CMD_PUSH: begin
                     if (stop_ff || full) begin
                        res_status_in = cptq_pkg::ST_REJECTED;
                     end else begin
                        pos_in   = fill_ff;
                        state_in = S_PUSH_RD;
                     end
                  end
                  cptq_pkg::CMD_POP: begin
                     state_in = S_POP_RD;
                  end
                  cptq_pkg::CMD_CANCEL: begin
                     state_in = S_CAN_RD;
                  end
                  cptq_pkg::CMD_STOP: begin
                     stop_in       = 1'b1;
                     res_status_in = cptq_pkg::ST_ACCEPTED;
                  end
                  cptq_pkg::CMD_DRAIN: begin
                     fill_in = '0;
                     if (live_ff == '0) begin
                        res_status_in = cptq_pkg::ST_NONE;
                     end else begin
                        state_in = S_DRN_RD;
                     end
                  end
                  default: begin
                     res_status_in = cptq_pkg::ST_REJECTED;
                  end
               endcase
            end
         end

         // walk down from the tail, opening a gap for the new entry
         S_PUSH_RD: begin
            if (pos_ff == '0) begin
               mem_wr_en     = 1'b1;
               mem_wr_data   = new_entry;
               fill_in       = fill_ff + CNT_W'(1);
               live_in       = live_ff + CNT_W'(1);
               res_status_in = cptq_pkg::ST_ACCEPTED;
               state_in      = S_EMIT;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_PUSH_CMP;
            end
         end

         S_PUSH_CMP: begin
            mem_wr_en = 1'b1;
            if (cmp.precedes) begin
               mem_wr_data   = new_entry;
               fill_in       = fill_ff + CNT_W'(1);
               live_in       = live_ff + CNT_W'(1);
               res_status_in = cptq_pkg::ST_ACCEPTED;
               state_in      = S_EMIT;
            end else begin
               mem_wr_data = mem_rd_data;
               pos_in      = pos_ff - CNT_W'(1);
               state_in    = S_PUSH_RD;
            end
         end

         // remove from the front until a live entry comes out or the queue is empty
         S_POP_RD: begin
            if (fill_ff == '0) begin
               res_status_in = cptq_pkg::ST_NONE;
               state_in      = S_EMIT;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_POP_CHK;
            end
         end

         S_POP_CHK: begin
            head_in = head_next;
            fill_in = fill_ff - CNT_W'(1);
            if (!mem_rd_data.cancelled) begin
               live_in       = live_ff - CNT_W'(1);
               res_status_in = cptq_pkg::ST_TASK;
               res_handle_in = mem_rd_data.handle;
               state_in      = S_EMIT;
            end else begin
               state_in = S_POP_RD;
            end
         end

         // mark every live entry with the key
         S_CAN_RD: begin
            if (pos_ff == fill_ff) begin
               live_in       = live_ff - count_ff;
               res_status_in = cptq_pkg::ST_ACCEPTED;
               res_count_in  = count_w32[cptq_pkg::COUNT_W-1:0];
               state_in      = S_EMIT;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_CAN_CHK;
            end
         end

         S_CAN_CHK: begin
            mem_wr_data           = mem_rd_data;
            mem_wr_data.cancelled = 1'b1;
            if (cmp.key_hit && !mem_rd_data.cancelled) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
            pos_in   = pos_ff + CNT_W'(1);
            state_in = S_CAN_RD;
         end

         // hand out live entries one beat each, stop after the last live one
         S_DRN_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_DRN_CHK;
         end

         S_DRN_CHK: begin
            if (mem_rd_data.cancelled) begin
               pos_in   = pos_ff + CNT_W'(1);
               state_in = S_DRN_RD;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cptq_pkg::ST_TASK;
               rsp_handle_in = mem_rd_data.handle;
               rsp_count_in  = '0;
               rsp_occ_in    = fill_w32[cptq_pkg::COUNT_W-1:0];
               rsp_stop_in   = stop_ff;
               rsp_last_in   = (count_ff + CNT_W'(1)) == live_ff;
               count_in      = count_ff + CNT_W'(1);
               pos_in        = pos_ff + CNT_W'(1);
               if ((count_ff + CNT_W'(1)) == live_ff) begin
                  live_in  = '0;
                  head_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_DRN_RD;
               end
            end
         end

         // load the single response beat of the item
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_count_in  = res_count_ff;
               rsp_occ_in    = fill_w32[cptq_pkg::COUNT_W-1:0];
               rsp_stop_in   = stop_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         live_ff      <= '0;
         stop_ff      <= 1'b0;
         cap_ff       <= cptq_pkg::CAP_RESET;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         live_ff      <= live_in;
         stop_ff      <= stop_in;
         cap_ff       <= cap_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      itm_handle_ff <= itm_handle_in;
      itm_prio_ff   <= itm_prio_in;
      itm_time_ff   <= itm_time_in;
      itm_key_ff    <= itm_key_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_stop_ff   <= rsp_stop_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // response packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_stop_ff, rsp_occ_ff, rsp_count_ff, rsp_handle_ff};

endmodule

@@ hw/rtl/cptq_chk.sv @@
// port checker for the task queue, bound to the top level
module cptq_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [cptq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [cptq_pkg::STATUS_W-1:0]       rsp_tuser,
   input logic                                rsp_tlast
);

   // a stalled response beat holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // the sequencer is busy right after taking an item
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous item in work");

   // only drain beats come without last, and they carry tasks
   a_mid_beat_task: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == cptq_pkg::ST_TASK)
      else $error("non-final beat without a task");

   // handle is zero unless a task is returned
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cptq_pkg::ST_TASK |-> rsp_tdata[15:0] == '0)
      else $error("handle set on a beat without a task");

   // cancel count only on accepted beats
   a_count_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20:16] != '0 |-> rsp_tuser == cptq_pkg::ST_ACCEPTED)
      else $error("cancel count on a beat that is not accepted");

endmodule

bind cancellable_priority_task_queue_unit cptq_chk u_cptq_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
